// File: hdl/rft_pkg.sv
// shared types and constants for the register-and-forward table
// no dependencies; used by rft_ctrl, rft_datapath and the top level
package rft_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // packet header constants
    localparam logic [15:0] REG_SOCKET    = 16'h0002;
    localparam logic [31:0] REG_HOST      = 32'h0000_0000;
    localparam logic [31:0] BCAST_HOST    = 32'hffff_ffff;
    localparam logic [15:0] DEFAULT_PORT  = 16'd213;
    localparam logic [7:0]  MAC_REQ       = 8'h4d;
    localparam logic [10:0] MAC_MIN_LEN   = 11'd36;
    localparam logic [10:0] EMPTY_LEN     = 11'd0;
    localparam logic [31:0] SERVER_ID_RST = 32'd1;

    // result kinds
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_FWD = 1'b1;

    // input request, last field (sender_peer) in the low bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] mac_port;
        logic [31:0] mac_host;
        logic [10:0] packet_len;
        logic [7:0]  trans_control;
        logic [15:0] src_port;
        logic [31:0] src_host;
        logic [15:0] dest_port;
        logic [31:0] dest_host;
        logic [15:0] dest_socket;
        logic [31:0] sender_peer;
    } in_item_t;

    // one result
    typedef struct packed {
        logic        kind;
        logic        last;
        logic [15:0] node_port;
        logic [31:0] node_host;
        logic        ext_ack;
        logic [31:0] from_host;
        logic [3:0]  slot;
        logic [31:0] target_peer;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REG_SCAN,
        ST_FWD_SCAN,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic claim;
        logic set_ack;
        logic set_fwd;
        logic push;
        logic flush;
    } rft_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic is_reg;
        logic slot_free;
        logic src_match;
        logic fwd_hit;
        logic idx_last;
        logic cnt_full;
        logic pend_valid;
        logic out_free;
    } rft_stat_t;

endpackage

// File: hdl/ipx_register_and_forward_table.sv
// top level: IPX tunnel registration and forwarding table, one request at a time
// each request is captured, then the slots are scanned in order, then the held result is flushed;
// an empty packet is only captured, a registration scan stops at the first free or matching slot,
// a registration miss then forwards; the last result shows up in the cycle the next request can be taken
// a result waiting on m_tready stalls the scan; reset (aresetn low, synchronous) clears
// all slots and sets server_id to 1; depends on rft_pkg, rft_ctrl and rft_datapath
module ipx_register_and_forward_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sender_peer, dest_socket, dest_host, dest_port, src_host, src_port,
    // trans_control, packet_len, mac_host, mac_port, zero pad
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // target_peer, slot, from_host, ext_ack, node_host, node_port, zero pad
    output logic [119:0] m_tdata,
    // kind
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    rft_pkg::rft_cmd_t  cmd;
    rft_pkg::rft_stat_t stat;
    rft_pkg::in_item_t  in_item;
    rft_pkg::result_t   out_item;

    assign in_item = rft_pkg::in_item_t'(s_tdata);

    rft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rft_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (out_item)
    );

    // result packing
    assign m_tdata = {3'b000, out_item.node_port, out_item.node_host, out_item.ext_ack,
                      out_item.from_host, out_item.slot, out_item.target_peer};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule

// File: hdl/rft_ctrl.sv
// scan controller for the register-and-forward table
// depends on rft_pkg for state, command and status types
module rft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rft_pkg::rft_stat_t stat,
    output rft_pkg::rft_cmd_t  cmd
);

    rft_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rft_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (stat.empty) begin
                        state_next = rft_pkg::ST_IDLE;
                    end else if (stat.is_reg) begin
                        state_next = rft_pkg::ST_REG_SCAN;
                    end else begin
                        state_next = rft_pkg::ST_FWD_SCAN;
                    end
                end
            end
            rft_pkg::ST_REG_SCAN: begin
                if (stat.slot_free) begin
                    cmd.claim   = 1'b1;
                    cmd.set_ack = 1'b1;
                    state_next  = rft_pkg::ST_FLUSH;
                end else if (stat.src_match) begin
                    cmd.set_ack = 1'b1;
                    state_next  = rft_pkg::ST_FLUSH;
                end else if (stat.idx_last) begin
                    // no slot took it, fall back to forwarding
                    cmd.idx_clr = 1'b1;
                    state_next  = rft_pkg::ST_FWD_SCAN;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            rft_pkg::ST_FWD_SCAN: begin
                // stall only when a new hit must displace a held result and the output register is busy
                if (!(stat.fwd_hit && !stat.cnt_full && stat.pend_valid
                      && !stat.out_free)) begin
                    if (stat.fwd_hit && !stat.cnt_full) begin
                        cmd.set_fwd = 1'b1;
                        cmd.push    = stat.pend_valid;
                    end
                    if (stat.idx_last) begin
                        state_next = rft_pkg::ST_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            rft_pkg::ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = rft_pkg::ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = rft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rft_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rft_datapath.sv
// slot table, scan index, held result and output register
// depends on rft_pkg for item, result, command and status types
module rft_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  rft_pkg::in_item_t  in_item,
    input  rft_pkg::rft_cmd_t  cmd,
    output rft_pkg::rft_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output rft_pkg::result_t   out_item
);

    logic [31:0]               server_id_reg;
    rft_pkg::in_item_t         in_reg;
    logic [rft_pkg::SLOT_W-1:0] idx_reg;
    logic [rft_pkg::CNT_W-1:0]  cnt_reg;
    rft_pkg::result_t          pend_reg;
    logic                      pend_valid_reg;
    rft_pkg::result_t          out_reg;
    rft_pkg::result_t          out_next;
    logic                      out_valid_reg;

    logic [rft_pkg::SLOTS-1:0] conn_reg;
    logic [31:0]               guest_host_reg [rft_pkg::SLOTS];
    logic [15:0]               guest_port_reg [rft_pkg::SLOTS];
    logic [31:0]               peer_reg       [rft_pkg::SLOTS];

    logic [31:0]      cur_host;
    logic [15:0]      cur_port;
    logic [31:0]      cur_peer;
    logic             ext;
    logic             bcast;
    logic             src_eq;
    logic             dst_eq;
    rft_pkg::result_t ack_res;
    rft_pkg::result_t fwd_res;

    // current slot entry
    assign cur_host = guest_host_reg[idx_reg];
    assign cur_port = guest_port_reg[idx_reg];
    assign cur_peer = peer_reg[idx_reg];

    // compares against the header addresses
    assign src_eq = (cur_host == in_reg.src_host) && (cur_port == in_reg.src_port);
    assign dst_eq = (cur_host == in_reg.dest_host) && (cur_port == in_reg.dest_port);
    assign bcast  = (in_reg.dest_host == rft_pkg::BCAST_HOST);
    assign ext    = cmd.claim && (in_reg.trans_control == rft_pkg::MAC_REQ)
                    && (in_reg.packet_len >= rft_pkg::MAC_MIN_LEN);

    // status to controller
    always_comb begin
        stat.empty      = (in_item.packet_len == rft_pkg::EMPTY_LEN);
        stat.is_reg     = (in_item.dest_socket == rft_pkg::REG_SOCKET)
                          && (in_item.dest_host == rft_pkg::REG_HOST);
        stat.slot_free  = !conn_reg[idx_reg];
        stat.src_match  = src_eq;
        stat.fwd_hit    = conn_reg[idx_reg] && (bcast ? !src_eq : dst_eq);
        stat.idx_last   = (idx_reg == rft_pkg::SLOT_W'(rft_pkg::SLOTS - 1));
        stat.cnt_full   = (cnt_reg == rft_pkg::CNT_W'(rft_pkg::MAX_OUT));
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // ack and forward results for the current slot
    always_comb begin
        ack_res.kind        = rft_pkg::KIND_ACK;
        ack_res.last        = 1'b1;
        ack_res.target_peer = in_reg.sender_peer;
        ack_res.slot        = 4'(idx_reg);
        ack_res.from_host   = server_id_reg;
        ack_res.ext_ack     = ext;
        ack_res.node_host   = ext ? in_reg.mac_host : in_reg.sender_peer;
        ack_res.node_port   = ext ? in_reg.mac_port : rft_pkg::DEFAULT_PORT;

        fwd_res.kind        = rft_pkg::KIND_FWD;
        fwd_res.last        = 1'b0;
        fwd_res.target_peer = cur_peer;
        fwd_res.slot        = 4'(idx_reg);
        fwd_res.from_host   = in_reg.src_host;
        fwd_res.ext_ack     = 1'b0;
        fwd_res.node_host   = in_reg.dest_host;
        fwd_res.node_port   = in_reg.dest_port;
    end

    // server id register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_id_reg <= rft_pkg::SERVER_ID_RST;
        end else if (cfg_wr_en) begin
            server_id_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= in_item;
        end
    end

    // scan index and result count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.set_fwd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // connected flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg <= '0;
        end else if (cmd.claim) begin
            conn_reg[idx_reg] <= 1'b1;
        end
    end

    // slot contents, written on claim
    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            peer_reg[idx_reg]       <= in_reg.sender_peer;
            guest_host_reg[idx_reg] <= ext ? in_reg.mac_host : in_reg.sender_peer;
            guest_port_reg[idx_reg] <= ext ? in_reg.mac_port : rft_pkg::DEFAULT_PORT;
        end
    end

    // held result, sent once the next one or the end of scan is known
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.set_ack || cmd.set_fwd) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush || cmd.load) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_ack) begin
            pend_reg <= ack_res;
        end else if (cmd.set_fwd) begin
            pend_reg <= fwd_res;
        end
    end

    // output word: held result, last set only by the final flush
    always_comb begin
        out_next      = pend_reg;
        out_next.last = cmd.flush;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push || cmd.flush) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push || cmd.flush) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: verif/ipx_register_and_forward_table_tb.sv
// testbench for ipx_register_and_forward_table: stream requests, table predictor and scoreboard
// drives directed and random tunnel packets across several server_id settings
// depends on rft_pkg and the ipx_register_and_forward_table rtl
module ipx_register_and_forward_table_tb;

    localparam int DRAIN_CYCLES = 2 * rft_pkg::SLOTS + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 4;
    localparam int PHASE_ITEMS  = 50;

    // table predictor plus queue of expected results
    class rft_scoreboard;
        logic [31:0]      server_id;
        bit               connected [rft_pkg::SLOTS];
        logic [31:0]      guest_host [rft_pkg::SLOTS];
        logic [15:0]      guest_port [rft_pkg::SLOTS];
        logic [31:0]      peer_of [rft_pkg::SLOTS];
        rft_pkg::result_t expected_q [$];
        int               errors;
        int               n_req, n_empty, n_ack, n_ext, n_fwd, widest;

        function new();
            server_id = rft_pkg::SERVER_ID_RST;
            for (int i = 0; i < rft_pkg::SLOTS; i++) connected[i] = 1'b0;
            errors = 0;
            n_req = 0; n_empty = 0; n_ack = 0; n_ext = 0; n_fwd = 0; widest = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // random connected guest address, 0 when the table is empty
        function bit pick_guest(output logic [31:0] h, output logic [15:0] p);
            int idx [$];
            int k;
            for (int i = 0; i < rft_pkg::SLOTS; i++)
                if (connected[i]) idx.push_back(i);
            if (idx.size() == 0) return 1'b0;
            k = idx[$urandom_range(idx.size() - 1)];
            h = guest_host[k];
            p = guest_port[k];
            return 1'b1;
        endfunction

        function void push_ack(int i, logic [31:0] target, bit ext,
                               logic [31:0] nh, logic [15:0] np);
            rft_pkg::result_t e;
            e.kind = rft_pkg::KIND_ACK; e.target_peer = target; e.slot = i[3:0];
            e.from_host = server_id; e.ext_ack = ext;
            e.node_host = nh; e.node_port = np; e.last = 1'b1;
            expected_q.push_back(e);
            n_ack++;
            if (ext) n_ext++;
        endfunction

        // work out what an accepted request produces and update the table
        function void note_request(rft_pkg::in_item_t r);
            rft_pkg::result_t copies [$];
            rft_pkg::result_t e;
            bit               hit;
            bit               ext;
            n_req++;
            if (r.packet_len == rft_pkg::EMPTY_LEN) begin
                n_empty++;
                return;
            end
            // registration: first free slot is claimed, or a matching guest re-acked
            if (r.dest_socket == rft_pkg::REG_SOCKET && r.dest_host == rft_pkg::REG_HOST) begin
                for (int i = 0; i < rft_pkg::SLOTS; i++) begin
                    if (!connected[i]) begin
                        ext = (r.trans_control == rft_pkg::MAC_REQ)
                              && (r.packet_len >= rft_pkg::MAC_MIN_LEN);
                        peer_of[i]    = r.sender_peer;
                        guest_host[i] = ext ? r.mac_host : r.sender_peer;
                        guest_port[i] = ext ? r.mac_port : rft_pkg::DEFAULT_PORT;
                        connected[i]  = 1'b1;
                        push_ack(i, r.sender_peer, ext, guest_host[i], guest_port[i]);
                        return;
                    end
                    if (guest_host[i] == r.src_host && guest_port[i] == r.src_port) begin
                        push_ack(i, r.sender_peer, 1'b0, r.sender_peer, rft_pkg::DEFAULT_PORT);
                        return;
                    end
                end
            end
            // forwarding scan, capped at MAX_OUT copies
            for (int i = 0; i < rft_pkg::SLOTS && copies.size() < rft_pkg::MAX_OUT; i++) begin
                if (!connected[i]) continue;
                if (r.dest_host == rft_pkg::BCAST_HOST)
                    hit = (guest_host[i] != r.src_host) || (guest_port[i] != r.src_port);
                else
                    hit = (guest_host[i] == r.dest_host) && (guest_port[i] == r.dest_port);
                if (hit) begin
                    e.kind = rft_pkg::KIND_FWD; e.target_peer = peer_of[i]; e.slot = i[3:0];
                    e.from_host = r.src_host; e.ext_ack = 1'b0;
                    e.node_host = r.dest_host; e.node_port = r.dest_port; e.last = 1'b0;
                    copies.push_back(e);
                end
            end
            for (int k = 0; k < copies.size(); k++) begin
                e = copies[k];
                e.last = (k == copies.size() - 1);
                expected_q.push_back(e);
            end
            n_fwd += copies.size();
            if (copies.size() > widest) widest = copies.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(rft_pkg::result_t got);
            rft_pkg::result_t w;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: kind %0d slot %0d target %0h",
                       got.kind, got.slot, got.target_peer);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            compare_field("kind", 32'(w.kind), 32'(got.kind));
            compare_field("target_peer", w.target_peer, got.target_peer);
            compare_field("slot", 32'(w.slot), 32'(got.slot));
            compare_field("from_host", w.from_host, got.from_host);
            compare_field("ext_ack", 32'(w.ext_ack), 32'(got.ext_ack));
            compare_field("node_host", w.node_host, got.node_host);
            compare_field("node_port", 32'(w.node_port), 32'(got.node_port));
            compare_field("last", 32'(w.last), 32'(got.last));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [119:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    rft_scoreboard sb = new();
    bit steady    = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    ipx_register_and_forward_table u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result receiver: random backpressure plus one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 28);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        rft_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = m_tuser[0];
            got.last        = m_tlast;
            got.target_peer = m_tdata[31:0];
            got.slot        = m_tdata[35:32];
            got.from_host   = m_tdata[67:36];
            got.ext_ack     = m_tdata[68];
            got.node_host   = m_tdata[100:69];
            got.node_port   = m_tdata[116:101];
            sb.check_result(got);
        end
    end

    function automatic rft_pkg::in_item_t make_req(logic [31:0] sp, logic [15:0] ds,
                                                   logic [31:0] dh, logic [15:0] dp,
                                                   logic [31:0] sh, logic [15:0] spt,
                                                   logic [7:0] tc, logic [10:0] len,
                                                   logic [31:0] mh, logic [15:0] mp);
        rft_pkg::in_item_t r;
        r.pad = '0;
        r.sender_peer = sp; r.dest_socket = ds; r.dest_host = dh; r.dest_port = dp;
        r.src_host = sh; r.src_port = spt; r.trans_control = tc; r.packet_len = len;
        r.mac_host = mh; r.mac_port = mp;
        return r;
    endfunction

    // mostly well-formed traffic around the current table, some noise
    function automatic rft_pkg::in_item_t random_request();
        rft_pkg::in_item_t r;
        int                pick;
        logic [31:0]       gh;
        logic [15:0]       gp;
        r = make_req($urandom, 16'($urandom), $urandom, 16'($urandom), $urandom,
                     16'($urandom), 8'($urandom), 11'($urandom_range(2047)), $urandom,
                     16'($urandom));
        pick = $urandom_range(99);
        if (pick < 25) begin
            // registration, sometimes from a known guest
            r.dest_socket = rft_pkg::REG_SOCKET;
            r.dest_host   = rft_pkg::REG_HOST;
            if ($urandom_range(99) < 40 && sb.pick_guest(gh, gp)) begin
                r.src_host = gh;
                r.src_port = gp;
            end
            if ($urandom_range(1)) r.trans_control = rft_pkg::MAC_REQ;
            if ($urandom_range(1)) r.packet_len = 11'($urandom_range(30, 40));
        end else if (pick < 55) begin
            // unicast to a known guest
            if (sb.pick_guest(gh, gp)) begin
                r.dest_host = gh;
                r.dest_port = gp;
            end
        end else if (pick < 70) begin
            // broadcast, often from a connected guest
            r.dest_host = rft_pkg::BCAST_HOST;
            if ($urandom_range(1) && sb.pick_guest(gh, gp)) begin
                r.src_host = gh;
                r.src_port = gp;
            end
        end else if (pick < 78) begin
            r.packet_len = rft_pkg::EMPTY_LEN;
        end
        if (pick < 70 && r.packet_len == rft_pkg::EMPTY_LEN) r.packet_len = 11'd1;
        return r;
    endfunction

    // offer one request, optionally after a gap, and wait for its handshake
    task automatic send_request(rft_pkg::in_item_t req);
        if (!steady && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req);
    endtask

    // drop valid, let every expected result arrive, then let the scan finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_server_id(logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.server_id = value;
        cfg_wr_en   <= 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset server_id, empty table
        send_request(make_req(32'h11, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0, 32'h0,
                              16'h0, rft_pkg::MAC_REQ, rft_pkg::EMPTY_LEN, 32'h0, 16'h0));
        send_request(make_req(32'h22, 16'h4000, rft_pkg::BCAST_HOST, 16'hffff, 32'h1234,
                              16'h5678, 8'h0, 11'd64, 32'h0, 16'h0));
        // plain claim, extended claim, 'M' one byte short, reconnect, all-ones claim
        send_request(make_req(32'hA000_0001, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'h5, 16'h5, 8'h0, 11'd30, 32'h0, 16'h0));
        send_request(make_req(32'h0B00_0002, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'h6, 16'h6, rft_pkg::MAC_REQ, rft_pkg::MAC_MIN_LEN, 32'h0,
                              16'h0777));
        send_request(make_req(32'hC000_0003, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'h7, 16'h7, rft_pkg::MAC_REQ, rft_pkg::MAC_MIN_LEN - 11'd1,
                              32'hdead_beef, 16'hbeef));
        send_request(make_req(32'hD000_0004, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'hA000_0001, rft_pkg::DEFAULT_PORT, 8'h0, 11'd40, 32'h0,
                              16'h0));
        send_request(make_req(32'hffff_ffff, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'h0, 16'h0, rft_pkg::MAC_REQ, 11'd2047, 32'hffff_ffff,
                              16'hffff));
        // unicast, broadcast from a member and from outside, miss, socket 2 non-registration
        send_request(make_req(32'h99, 16'h4000, 32'hA000_0001, rft_pkg::DEFAULT_PORT,
                              32'hC000_0003, rft_pkg::DEFAULT_PORT, 8'h0, 11'd100, 32'h0,
                              16'h0));
        send_request(make_req(32'h98, 16'h4000, rft_pkg::BCAST_HOST, 16'hffff, 32'hA000_0001,
                              rft_pkg::DEFAULT_PORT, 8'h0, 11'd100, 32'h0, 16'h0));
        send_request(make_req(32'h97, 16'h4000, rft_pkg::BCAST_HOST, 16'hffff, 32'h4242,
                              16'h4242, 8'h0, 11'd1, 32'h0, 16'h0));
        send_request(make_req(32'h96, 16'h4000, 32'h1234, 16'h1, 32'h4242, 16'h4242,
                              8'h0, 11'd10, 32'h0, 16'h0));
        send_request(make_req(32'h95, rft_pkg::REG_SOCKET, 32'hA000_0001,
                              rft_pkg::DEFAULT_PORT, 32'h4242, 16'h4242, rft_pkg::MAC_REQ,
                              11'd50, 32'h0, 16'h0));

        // directed: zero server_id, reconnect and exact-length extended claim
        wait_idle();
        write_server_id(32'h0);
        send_request(make_req(32'h1, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'hffff_ffff, 16'hffff, 8'h0, 11'd36, 32'h0, 16'h0));
        send_request(make_req(32'h2, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0, 32'h8,
                              16'h8, rft_pkg::MAC_REQ, rft_pkg::MAC_MIN_LEN, 32'h1234_5678,
                              16'h0));

        // directed: all-ones server_id
        wait_idle();
        write_server_id(32'hffff_ffff);
        send_request(make_req(32'h3, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0,
                              32'hC000_0003, rft_pkg::DEFAULT_PORT, 8'h0, 11'd20, 32'h0,
                              16'h0));

        // random phases, one without idling, one with a long receiver hold-off
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            write_server_id($urandom_range(32'hffff_fffe, 1));
            steady   = (ph == 1);
            hold_req = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
        end
        steady = 1'b0;

        // directed tail on a full table: registration miss forwards, wide fan-outs
        send_request(make_req(32'h44, rft_pkg::REG_SOCKET, rft_pkg::REG_HOST, 16'h0777,
                              32'h0bad, 16'h0bad, 8'h0, 11'd60, 32'h0, 16'h0));
        send_request(make_req(32'h55, 16'h4000, rft_pkg::BCAST_HOST, 16'h0, 32'h0bad_f00d,
                              16'h0bad, 8'h0, 11'd60, 32'h0, 16'h0));
        send_request(make_req(32'hffff_ffff, 16'hffff, rft_pkg::BCAST_HOST, 16'hffff,
                              32'hffff_ffff, 16'hffff, 8'hff, 11'd2047, 32'hffff_ffff,
                              16'hffff));
        send_request(make_req(32'h0, 16'h0, 32'h0, 16'h0, 32'h0, 16'h0, 8'h0, 11'd1,
                              32'h0, 16'h0));

        wait_idle();
        $display("covered %0d requests (%0d empty) over seven server_id settings",
                 sb.n_req, sb.n_empty);
        $display("checked %0d acks (%0d extended) and %0d forwarded copies, widest fan-out %0d",
                 sb.n_ack, sb.n_ext, sb.n_fwd, sb.widest);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
